@@ sv/rsb_pkg.sv @@
// Shared types, constants and a clipping helper function for the RGB surface blitter.
package rsb_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 64;
  localparam int DEFAULT_MAX_HEIGHT = 64;

  localparam int COORD_W     = 8;
  localparam int DIM_W       = 7;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int LIN_W       = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BLIT  = 2'd2;

  localparam logic [1:0] ROP_COPY   = 2'd0;
  localparam logic [1:0] ROP_BLACK  = 2'd1;
  localparam logic [1:0] ROP_INVERT = 2'd2;
  localparam logic [1:0] ROP_WHITE  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 7'd64;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [1:0]         rop_code;
    logic [COLOR_W-1:0] color;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clip;
    logic rd;
    logic wr;
    logic adv;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       on_surf;
    logic       empty;
    logic       last;
    logic       out_free;
  } stat_t;

  // Clips a run of len starting at start against the bound limit.
  function automatic logic [DIM_W-1:0] clip_len(input logic [COORD_W-1:0] len,
                                                input logic [COORD_W-1:0] start,
                                                input logic [DIM_W-1:0]   limit);
    logic [DIM_W-1:0] rem;
    rem = limit - start[DIM_W-1:0];
    if (start >= {1'b0, limit}) begin
      return '0;
    end else if (len > {1'b0, rem}) begin
      return rem;
    end else begin
      return len[DIM_W-1:0];
    end
  endfunction

endpackage

@@ sv/rsb_if.sv @@
// Handshake interfaces for the request, response and configuration channels.
interface rsb_req_if;
  import rsb_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [COORD_W-1:0] dst_x;
  logic [COORD_W-1:0] dst_y;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic [1:0]         rop_code;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, opcode, dst_x, dst_y, src_x, src_y, rect_width,
                  rect_height, rop_code, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, dst_x, dst_y, src_x, src_y, rect_width,
                rect_height, rop_code, red_in, green_in, blue_in, output ready);
endinterface

interface rsb_rsp_if;
  import rsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              status;

  modport source (output valid, red_out, green_out, blue_out, status, input ready);
  modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface rsb_cfg_if;
  import rsb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [DIM_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rsb_datapath.sv @@
// Datapath: configuration, item registers, clipping, pixel walk, pixel store and result register.
module rsb_datapath import rsb_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  req_t                   req,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_data,
  input  logic                   rsp_ready,
  output logic                   rsp_valid,
  output rsp_t                   rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0]   width_in_use;
  logic [DIM_W-1:0]   height_in_use;
  logic [DIM_W-1:0]   surf_w;
  logic [DIM_W-1:0]   surf_h;
  req_t               item;
  logic [DIM_W-1:0]   clip_w;
  logic [DIM_W-1:0]   clip_h;
  logic [DIM_W-1:0]   clip_w_dst;
  logic [DIM_W-1:0]   clip_h_dst;
  logic [DIM_W-1:0]   clip_w_next;
  logic [DIM_W-1:0]   clip_h_next;
  logic [DIM_W-1:0]   row_idx;
  logic [DIM_W-1:0]   col_idx;
  logic               is_copy;
  logic               rev_y;
  logic               rev_x;
  logic [DIM_W-1:0]   row_off;
  logic [DIM_W-1:0]   col_off;
  logic [COORD_W-1:0] dst_row;
  logic [COORD_W-1:0] dst_col;
  logic [COORD_W-1:0] src_row;
  logic [COORD_W-1:0] src_col;
  logic [LIN_W-1:0]   dst_lin;
  logic [LIN_W-1:0]   src_lin;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [COLOR_W-1:0] wdata;
  logic [COLOR_W-1:0] rdata;
  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= DIM_RESET;
      height_in_use <= DIM_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_in_use <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        height_in_use <= cfg_data;
      end
    end
  end

  assign surf_w = ({2'b0, width_in_use} > 9'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_in_use;
  assign surf_h = ({2'b0, height_in_use} > 9'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : height_in_use;

  assign is_copy = (item.opcode == OP_BLIT) && (item.rop_code == ROP_COPY);
  assign rev_y   = is_copy && (item.dst_y > item.src_y);
  assign rev_x   = is_copy && (item.dst_y == item.src_y) && (item.dst_x > item.src_x);

  always_comb begin
    clip_w_dst  = clip_len(item.rect_width, item.dst_x, surf_w);
    clip_h_dst  = clip_len(item.rect_height, item.dst_y, surf_h);
    clip_w_next = clip_w_dst;
    clip_h_next = clip_h_dst;
    if (item.rop_code == ROP_COPY) begin
      clip_w_next = clip_len({1'b0, clip_w_dst}, item.src_x, surf_w);
      clip_h_next = clip_len({1'b0, clip_h_dst}, item.src_y, surf_h);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.clip) begin
      clip_w <= clip_w_next;
      clip_h <= clip_h_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      row_idx <= '0;
      col_idx <= '0;
    end else if (cmd.adv) begin
      if (col_idx == clip_w - 1'b1) begin
        col_idx <= '0;
        row_idx <= row_idx + 1'b1;
      end else begin
        col_idx <= col_idx + 1'b1;
      end
    end
  end

  assign row_off = rev_y ? (clip_h - 1'b1 - row_idx) : row_idx;
  assign col_off = rev_x ? (clip_w - 1'b1 - col_idx) : col_idx;
  assign dst_row = item.dst_y + {1'b0, row_off};
  assign dst_col = item.dst_x + {1'b0, col_off};
  assign src_row = item.src_y + {1'b0, row_off};
  assign src_col = item.src_x + {1'b0, col_off};
  assign dst_lin = {8'b0, dst_row} * {9'b0, surf_w} + {8'b0, dst_col};
  assign src_lin = {8'b0, src_row} * {9'b0, surf_w} + {8'b0, src_col};
  assign wr_addr = dst_lin[AW-1:0];
  assign rd_addr = is_copy ? src_lin[AW-1:0] : dst_lin[AW-1:0];

  always_comb begin
    if (item.opcode == OP_WRITE) begin
      wdata = item.color;
    end else begin
      case (item.rop_code)
        ROP_COPY:   wdata = rdata;
        ROP_BLACK:  wdata = COLOR_BLACK;
        ROP_INVERT: wdata = ~rdata;
        ROP_WHITE:  wdata = COLOR_WHITE;
        default:    wdata = COLOR_BLACK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  assign stat.opcode   = item.opcode;
  assign stat.on_surf  = (item.dst_x < {1'b0, surf_w}) && (item.dst_y < {1'b0, surf_h});
  assign stat.empty    = (clip_w == '0) || (clip_h == '0);
  assign stat.last     = (col_idx == clip_w - 1'b1) && (row_idx == clip_h - 1'b1);
  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      rsp.color  <= (item.opcode == OP_READ && stat.on_surf) ? rdata : COLOR_BLACK;
      rsp.status <= (item.opcode == OP_READ) && !stat.on_surf;
    end
  end

endmodule

@@ sv/rsb_ctrl.sv @@
// Controller state machine that sequences pixel operations and the blit walk.
module rsb_ctrl import rsb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_BCHK = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BWR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.clip = 1'b1;
        case (stat.opcode)
          OP_WRITE: begin
            cmd.wr     = stat.on_surf;
            state_next = S_FIN;
          end
          OP_READ: begin
            cmd.rd     = stat.on_surf;
            state_next = S_FIN;
          end
          OP_BLIT:  state_next = S_BCHK;
          default:  state_next = S_FIN;
        endcase
      end
      S_BCHK: begin
        state_next = stat.empty ? S_FIN : S_BRD;
      end
      S_BRD: begin
        cmd.rd     = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.wr     = 1'b1;
        cmd.adv    = 1'b1;
        state_next = stat.last ? S_FIN : S_BRD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/rgb_surface_blitter_top.sv @@
// Top level of the RGB surface blitter: controller, datapath and channel wiring.
// A pixel write or read passes the decode and finish states; its result is registered when the
// finish state finds the output free. A blit passes decode and a clip check, then walks each
// clipped pixel with a read state and then a write state on the pixel store before finishing.
// A new request is accepted in the cycle after the previous result is registered.
// Reset clears the controller, the result valid and sets both surface sizes to 64;
// the pixel store is not cleared and holds undefined data until written.
module rgb_surface_blitter_top import rsb_pkg::*; #(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
  input logic      clk,
  input logic      rst,
  rsb_req_if.sink  req,
  rsb_rsp_if.source rsp,
  rsb_cfg_if.sink  cfg
);

  req_t  req_data;
  rsp_t  rsp_data;
  cmd_t  cmd;
  stat_t stat;

  always_comb begin
    req_data.opcode      = req.opcode;
    req_data.dst_x       = req.dst_x;
    req_data.dst_y       = req.dst_y;
    req_data.src_x       = req.src_x;
    req_data.src_y       = req.src_y;
    req_data.rect_width  = req.rect_width;
    req_data.rect_height = req.rect_height;
    req_data.rop_code    = req.rop_code;
    req_data.color       = {req.red_in, req.green_in, req.blue_in};
  end

  assign cfg.ready     = 1'b1;
  assign rsp.red_out   = rsp_data.color[23:16];
  assign rsp.green_out = rsp_data.color[15:8];
  assign rsp.blue_out  = rsp_data.color[7:0];
  assign rsp.status    = rsp_data.status;

  rsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp       (rsp_data)
  );

endmodule
